>>> hdl/ev2raw_pkg.sv
// Shared types and constants for the event to raw word encoder.
package ev2raw_pkg;

   localparam int TS_W      = 64;
   localparam int ROW_W     = 16;
   localparam int COL_W     = 12;
   localparam int WORD_W    = 16;
   localparam int REQ_DATA_W = 96;
   localparam int RSP_USER_W = 3;

   localparam int TS_ENC_W  = 15;
   localparam int POS_ENC_W = 12;

   localparam logic [WORD_W-1:0] TS_WORD_SUBST = 16'h7001;
   localparam logic [3:0]        ROW_TAG       = 4'h1;
   localparam logic [2:0]        COL_TAG_HI    = 3'h1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Which word of an event the back end is sending.
   typedef enum logic [2:0] {
      PHASE_TS  = 3'b001,
      PHASE_ROW = 3'b010,
      PHASE_COL = 3'b100
   } phase_type;

   typedef struct packed {
      logic ts_changed;
      logic row_changed;
      logic ts_backwards;
   } flags_type;

   // One classified event, as it waits between front and back end.
   typedef struct packed {
      logic [WORD_W-1:0] ts_word;
      logic [WORD_W-1:0] row_word;
      logic [WORD_W-1:0] col_word;
      flags_type         flags;
   } entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

>>> hdl/ev2raw_front.sv
// Front end: accepts events, compares them with the stored ones and builds the words.
module ev2raw_front
   import ev2raw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  queue_status_type      q_status,
   output logic                  push,
   output entry_type             push_entry
);

   logic [TS_W-1:0]  prev_ts_ff, prev_ts_in;
   logic [ROW_W-1:0] prev_row_ff, prev_row_in;

   logic [TS_W-1:0]  ts;
   logic [ROW_W-1:0] row;
   logic [COL_W-1:0] col;
   logic             pol;
   logic             ts_diff;

   assign ts  = req_tdata[TS_W-1:0];
   assign row = req_tdata[TS_W+ROW_W-1:TS_W];
   assign col = req_tdata[TS_W+ROW_W+COL_W-1:TS_W+ROW_W];
   assign pol = req_tdata[TS_W+ROW_W+COL_W];

   assign req_tready = !q_status.full;
   assign push       = req_tvalid && req_tready;
   assign ts_diff    = (ts != prev_ts_ff);

   always_comb begin
      if (ts[TS_ENC_W-1:0] == '0) begin
         push_entry.ts_word = TS_WORD_SUBST;
      end else begin
         push_entry.ts_word = {1'b1, ts[TS_ENC_W-1:0]};
      end
      push_entry.row_word           = {ROW_TAG, row[POS_ENC_W-1:0]};
      push_entry.col_word           = {COL_TAG_HI, pol, col};
      push_entry.flags.ts_changed   = ts_diff;
      push_entry.flags.row_changed  = !ts_diff && (row != prev_row_ff);
      push_entry.flags.ts_backwards = (ts < prev_ts_ff);
   end

   always_comb begin
      prev_ts_in  = prev_ts_ff;
      prev_row_in = prev_row_ff;
      if (push) begin
         prev_ts_in  = ts;
         prev_row_in = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ts_ff  <= '0;
         prev_row_ff <= '0;
      end else begin
         prev_ts_ff  <= prev_ts_in;
         prev_row_ff <= prev_row_in;
      end
   end

endmodule

>>> hdl/ev2raw_queue.sv
// Short queue of classified events between the front and back ends.
module ev2raw_queue
   import ev2raw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head_entry,
   output queue_status_type q_status
);

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign head_entry         = slot_ff[rd_ptr_ff];
   assign q_status.not_empty = (count_ff != '0);
   assign q_status.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/ev2raw_back.sv
// Back end: sends the words of one queued event, one word per transfer.
module ev2raw_back
   import ev2raw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  entry_type             head_entry,
   input  queue_status_type      q_status,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [WORD_W-1:0]     rsp_tdata,
   output logic                  rsp_tlast,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   entry_type cur_ff, cur_in;
   logic      cur_valid_ff, cur_valid_in;
   phase_type phase_ff, phase_in;

   logic out_xfer;
   logic load;

   assign rsp_tvalid = cur_valid_ff;
   assign rsp_tlast  = (phase_ff == PHASE_COL);
   assign rsp_tuser  = {cur_ff.flags.ts_backwards, cur_ff.flags.row_changed,
                        cur_ff.flags.ts_changed};

   always_comb begin
      case (phase_ff)
         PHASE_TS:  rsp_tdata = cur_ff.ts_word;
         PHASE_ROW: rsp_tdata = cur_ff.row_word;
         PHASE_COL: rsp_tdata = cur_ff.col_word;
         default:   rsp_tdata = cur_ff.col_word;
      endcase
   end

   assign out_xfer = rsp_tvalid && rsp_tready;
   // The next event is taken as soon as the last word of the current one goes out.
   assign load     = !cur_valid_ff || (out_xfer && rsp_tlast);
   assign pop      = load && q_status.not_empty;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      phase_in     = phase_ff;
      if (load) begin
         cur_in       = head_entry;
         cur_valid_in = q_status.not_empty;
         if (head_entry.flags.ts_changed) begin
            phase_in = PHASE_TS;
         end else if (head_entry.flags.row_changed) begin
            phase_in = PHASE_ROW;
         end else begin
            phase_in = PHASE_COL;
         end
      end else if (out_xfer) begin
         case (phase_ff)
            PHASE_TS:  phase_in = PHASE_ROW;
            PHASE_ROW: phase_in = PHASE_COL;
            default:   phase_in = PHASE_COL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         phase_ff     <= PHASE_COL;
      end else begin
         cur_valid_ff <= cur_valid_in;
         phase_ff     <= phase_in;
      end
   end

endmodule

>>> hdl/event_to_raw_word_encoder.sv
// Event to raw word encoder: 16-bit raw words from timestamped camera events.
//
// Each event on the req channel (timestamp, row, column, polarity) is
// compared with the previous event and becomes one to three 16-bit words on
// the rsp channel: a timestamp word, a row word and a column word when the
// timestamp changed, row and column words when only the row changed, and the
// column word alone otherwise. rsp_tlast marks the last word of an event;
// rsp_tuser carries the change flags, the same on every word of one event.
// When the block is empty, an event is written to a queue slot and then loaded
// into the back end's current-event register before its first word is valid.
// The word serializer in the back end sends one word per cycle while
// rsp_tready is high and events wait; up to three events in all may
// wait inside, two in the queue.
// Reset clears the stored timestamp and row to zero and empties the block.
// When the receiver holds rsp_tready low the current word stays put, the
// queue fills and then req_tready drops until words move again.
module event_to_raw_word_encoder
   import ev2raw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: timestamp[63:0], row[79:64], column[91:80],
   // polarity[92], zero fill [95:93].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: raw_word[15:0].
   output logic [WORD_W-1:0]     rsp_tdata,
   output logic                  rsp_tlast,
   // Fields from bit 0: ts_changed[0], row_changed[1], ts_backwards[2].
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   queue_status_type q_status;
   entry_type        push_entry;
   entry_type        head_entry;
   logic             push;
   logic             pop;

   ev2raw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   ev2raw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_status   (q_status)
   );

   ev2raw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
